>>> hw/rtl/pfre_pkg.sv
// ----------------------------------------------------------------------------
// pfre_pkg
// shared command codes, mask and read-modify-write types for the
// page-addressed framebuffer raster engine
// ----------------------------------------------------------------------------
package pfre_pkg;

    // command codes carried in the kind field
    localparam logic [2:0] KIND_CLEAR   = 3'd0;
    localparam logic [2:0] KIND_PIXEL   = 3'd1;
    localparam logic [2:0] KIND_OUTLINE = 3'd2;
    localparam logic [2:0] KIND_FILL    = 3'd3;
    localparam logic [2:0] KIND_BLIT    = 3'd4;
    localparam logic [2:0] KIND_READ    = 3'd5;

    localparam int ROWS_PER_PAGE = 8;
    localparam int COORD_W       = 16;

    typedef logic [COORD_W-1:0]       coord_t;
    typedef logic [ROWS_PER_PAGE-1:0] byte_mask_t;

    // row masks for one page: span_mask applies on columns inside the
    // horizontal span, edge_mask on the edge columns
    typedef struct packed {
        byte_mask_t span_mask;
        byte_mask_t edge_mask;
    } row_mask_t;

    // one read-modify-write request, travels with the read of its byte
    typedef struct packed {
        logic       valid;
        logic       on;
        byte_mask_t hit;
    } rmw_t;

endpackage

>>> hw/rtl/pfre_rowmask.sv
// ----------------------------------------------------------------------------
// pfre_rowmask
// per-page row masks: which of the eight rows of a page a command touches
// ----------------------------------------------------------------------------
module pfre_rowmask #(
    parameter int HEIGHT = 64,
    parameter int PW     = 3
) (
    input  logic [PW-1:0]       page,
    input  logic [2:0]          kind,
    input  pfre_pkg::coord_t    y,
    input  pfre_pkg::coord_t    h,
    input  pfre_pkg::coord_t    yb,
    input  logic [7:0]          data,
    output pfre_pkg::row_mask_t mask
);
    import pfre_pkg::*;

    always_comb
    begin
        coord_t r;
        coord_t d;
        logic   row_ok;
        logic   rin;
        logic   edge_row;
        logic   blit_bit;
        mask = '0;
        for (int i = 0; i < ROWS_PER_PAGE; i++)
        begin
            r        = COORD_W'({page, 3'(i)});
            d        = r - y;
            row_ok   = r < COORD_W'(HEIGHT);
            rin      = d < h;
            edge_row = (r == y) || (r == yb);
            blit_bit = (d < COORD_W'(ROWS_PER_PAGE)) && rin && data[d[2:0]];
            case (kind)
                KIND_FILL:
                begin
                    mask.span_mask[i] = row_ok && rin;
                end
                KIND_OUTLINE:
                begin
                    mask.span_mask[i] = row_ok && edge_row;
                    mask.edge_mask[i] = row_ok && rin;
                end
                KIND_PIXEL:
                begin
                    mask.edge_mask[i] = row_ok && (r == y);
                end
                KIND_BLIT:
                begin
                    mask.edge_mask[i] = row_ok && blit_bit;
                end
                default:
                begin
                    mask.span_mask[i] = 1'b0;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/pfre_store.sv
// ----------------------------------------------------------------------------
// pfre_store
// frame byte memory with one registered read port and a write-back stage
// that applies a set or clear mask to the byte read the cycle before
// ----------------------------------------------------------------------------
module pfre_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    input  pfre_pkg::rmw_t     rmw,
    input  logic               clr_en,
    input  logic [AW-1:0]      clr_addr,
    output logic [7:0]         rd_data
);
    import pfre_pkg::*;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    rmw_t          wb_reg;
    logic [AW-1:0] wb_addr_reg;
    logic [7:0]    wb_byte;

    // modified byte from the registered read data
    assign wb_byte = wb_reg.on ? (rd_data_reg | wb_reg.hit) : (rd_data_reg & ~wb_reg.hit);
    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wb_reg.valid)
        begin
            mem[wb_addr_reg] <= wb_byte;
        end
        else if (clr_en)
        begin
            mem[clr_addr] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg <= '0;
        end
        else
        begin
            wb_reg <= rmw;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg <= rd_addr;
    end

    // a write-back never lands on the byte being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (wb_reg.valid && rd_en) |-> (rd_addr != wb_addr_reg))
        else $error("pfre_store: read of byte under write-back");

    // modify requests always come with the read of their byte
    assert property (@(posedge clk) disable iff (!rst_n)
        rmw.valid |-> rd_en)
        else $error("pfre_store: modify request without read");

    // clearing sweep and write-back never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(clr_en && wb_reg.valid))
        else $error("pfre_store: clear during write-back");

endmodule

>>> hw/rtl/page_framebuffer_raster_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_raster_engine
// monochrome page-addressed framebuffer with pixel, rectangle, blit, clear
// and byte read commands
// ----------------------------------------------------------------------------
// The image lives in one byte-wide memory of STORE_BYTES entries; pixel
// (x,y) is bit y%8 of byte (y/8)*WIDTH+x. Drawing and read commands use
// that memory's single read port, and each command returns exactly one
// word on the output channel (the byte read for a read command, zero
// otherwise). After reset the block sweeps the memory to zero and holds
// in_stall high meanwhile; a clear command runs the same sweep. Drawing
// commands walk the pages of the screen, and on every page that holds a
// touched row they walk the columns one byte per cycle: pixel and blit
// only column x, rectangles every column. One command is in work at a
// time; a new one is accepted while the previous result still waits on
// the output register.
// ----------------------------------------------------------------------------
module page_framebuffer_raster_engine #(
    parameter int WIDTH       = 128,
    parameter int HEIGHT      = 64,
    parameter int STORE_BYTES = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    // command channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [2:0]       kind,
    input  pfre_pkg::coord_t x,
    input  pfre_pkg::coord_t y,
    input  pfre_pkg::coord_t w,
    input  pfre_pkg::coord_t h,
    input  logic             on,
    input  logic [7:0]       data,
    input  logic [9:0]       read_address,
    // result channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       read_data
);
    import pfre_pkg::*;

    // geometry
    localparam int PAGES = (HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW    = $clog2(WIDTH);
    localparam int AW    = $clog2(STORE_BYTES);
    localparam int BW    = $clog2(PAGES * WIDTH);
    localparam int IW    = (BW > AW) ? BW : AW;   // screen byte index width
    localparam int RW    = (AW > 10) ? AW : 10;   // read address compare width

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SETUP,
        ST_PAGE,
        ST_COL,
        ST_RDW,
        ST_CLR,
        ST_FIN
    } state_t;

    state_t        state_reg,     state_next;
    logic [2:0]    kind_reg,      kind_next;
    coord_t        x_reg,         x_next;
    coord_t        y_reg,         y_next;
    coord_t        w_reg,         w_next;
    coord_t        h_reg,         h_next;
    coord_t        xr_reg,        xr_next;
    coord_t        yb_reg,        yb_next;
    logic          on_reg,        on_next;
    logic [7:0]    data_reg,      data_next;
    logic [9:0]    raddr_reg,     raddr_next;
    logic [PW-1:0] page_reg,      page_next;
    logic [IW-1:0] base_reg,      base_next;
    logic [CW-1:0] col_reg,       col_next;
    logic [AW-1:0] clr_cnt_reg,   clr_cnt_next;
    row_mask_t     mask_reg,      mask_next;
    logic [7:0]    result_reg,    result_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    read_data_reg, read_data_next;

    // memory side
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    rmw_t          rmw;
    logic          clr_en;
    logic [7:0]    rd_data;

    // combinational helpers
    row_mask_t     row_mask;
    logic          is_rect;
    logic          last_page;
    logic          last_clr;
    logic [CW-1:0] col_start;
    logic [CW-1:0] col_end;
    coord_t        col16;
    logic          cin;
    logic          cedge;
    byte_mask_t    hit;
    logic [IW-1:0] idx;
    logic          idx_ok;
    logic [RW-1:0] ra_ext;
    logic          ra_ok;

    pfre_rowmask #(
        .HEIGHT (HEIGHT),
        .PW     (PW)
    ) u_rowmask (
        .page   (page_reg),
        .kind   (kind_reg),
        .y      (y_reg),
        .h      (h_reg),
        .yb     (yb_reg),
        .data   (data_reg),
        .mask   (row_mask)
    );

    pfre_store #(
        .DEPTH    (STORE_BYTES),
        .AW       (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rmw      (rmw),
        .clr_en   (clr_en),
        .clr_addr (clr_cnt_reg),
        .rd_data  (rd_data)
    );

    // rectangles scan all columns, pixel and blit only column x
    assign is_rect   = (kind_reg == KIND_OUTLINE) || (kind_reg == KIND_FILL);
    assign col_start = is_rect ? '0 : x_reg[CW-1:0];
    assign col_end   = is_rect ? CW'(WIDTH - 1) : x_reg[CW-1:0];
    assign last_page = page_reg == PW'(PAGES - 1);
    assign last_clr  = clr_cnt_reg == AW'(STORE_BYTES - 1);

    // column tests against the wrapped horizontal span and its edges
    assign col16 = COORD_W'(col_reg);
    assign cin   = (col16 - x_reg) < w_reg;
    assign cedge = (col16 == x_reg) || ((kind_reg == KIND_OUTLINE) && (col16 == xr_reg));
    assign hit   = (cin ? mask_reg.span_mask : '0) | (cedge ? mask_reg.edge_mask : '0);

    // byte index of the current page and column, dropped past the store
    assign idx    = base_reg + IW'(col_reg);
    assign idx_ok = {1'b0, idx} < (IW + 1)'(STORE_BYTES);

    // read command address check
    assign ra_ext = RW'(raddr_reg);
    assign ra_ok  = {1'b0, ra_ext} < (RW + 1)'(STORE_BYTES);

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        xr_next        = xr_reg;
        yb_next        = yb_reg;
        on_next        = on_reg;
        data_next      = data_reg;
        raddr_next     = raddr_reg;
        page_next      = page_reg;
        base_next      = base_reg;
        col_next       = col_reg;
        clr_cnt_next   = clr_cnt_reg;
        mask_next      = mask_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        rmw            = '0;
        clr_en         = 1'b0;

        // result word taken by the consumer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                // zero sweep after reset
                clr_en       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (last_clr)
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    x_next     = x;
                    y_next     = y;
                    w_next     = w;
                    h_next     = h;
                    on_next    = on;
                    data_next  = data;
                    raddr_next = read_address;
                    // far column and bottom row, wrapping at 16 bits
                    xr_next    = x + w - 1'b1;
                    yb_next    = y + h - 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                result_next = '0;
                page_next   = '0;
                base_next   = '0;
                unique case (kind_reg) inside
                    KIND_CLEAR:
                    begin
                        state_next = ST_CLR;
                    end
                    KIND_PIXEL, KIND_BLIT:
                    begin
                        // single column, dropped when off the screen
                        state_next = (x_reg < COORD_W'(WIDTH)) ? ST_PAGE : ST_FIN;
                    end
                    KIND_OUTLINE, KIND_FILL:
                    begin
                        // zero width or height draws nothing
                        state_next = ((w_reg != '0) && (h_reg != '0)) ? ST_PAGE : ST_FIN;
                    end
                    KIND_READ:
                    begin
                        rd_en      = ra_ok;
                        rd_addr    = ra_ext[AW-1:0];
                        state_next = ST_RDW;
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_PAGE:
            begin
                if ((row_mask.span_mask | row_mask.edge_mask) == '0)
                begin
                    // page untouched, skip its columns
                    if (last_page)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        page_next = page_reg + 1'b1;
                        base_next = base_reg + IW'(WIDTH);
                    end
                end
                else
                begin
                    mask_next  = row_mask;
                    col_next   = col_start;
                    state_next = ST_COL;
                end
            end
            ST_COL:
            begin
                // read the byte now, the store writes it back next cycle
                if (idx_ok && (hit != '0))
                begin
                    rd_en     = 1'b1;
                    rd_addr   = idx[AW-1:0];
                    rmw.valid = 1'b1;
                    rmw.on    = (kind_reg == KIND_BLIT) ? 1'b1 : on_reg;
                    rmw.hit   = hit;
                end
                if (col_reg == col_end)
                begin
                    if (last_page)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        page_next  = page_reg + 1'b1;
                        base_next  = base_reg + IW'(WIDTH);
                        state_next = ST_PAGE;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_RDW:
            begin
                result_next = ra_ok ? rd_data : '0;
                state_next  = ST_FIN;
            end
            ST_CLR:
            begin
                clr_en       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (last_clr)
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command and payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        xr_reg        <= xr_next;
        yb_reg        <= yb_next;
        on_reg        <= on_next;
        data_reg      <= data_next;
        raddr_reg     <= raddr_next;
        page_reg      <= page_next;
        base_reg      <= base_next;
        col_reg       <= col_next;
        mask_reg      <= mask_next;
        result_reg    <= result_next;
        read_data_reg <= read_data_next;
    end

    // a result word appears only when a command finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("raster engine: result word without finished command");

    // one command at a time: an accepted word blocks the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("raster engine: back-to-back command accept");

    // a waiting result word holds steady until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(read_data)))
        else $error("raster engine: stalled result word changed");

endmodule

>>> dv/tb_page_framebuffer_raster_engine.sv
// ----------------------------------------------------------------------------
// tb_page_framebuffer_raster_engine
// self-checking bench for the page-addressed framebuffer raster engine: a
// shadow framebuffer replays every accepted command and predicts the byte
// each result word must carry, under random idling and output back-pressure
// ----------------------------------------------------------------------------

// one command word as it crosses the input channel
typedef struct packed {
    logic [2:0]       kind;
    pfre_pkg::coord_t x;
    pfre_pkg::coord_t y;
    pfre_pkg::coord_t w;
    pfre_pkg::coord_t h;
    logic             on;
    logic [7:0]       data;
    logic [9:0]       read_address;
} raster_cmd_t;

// shadow framebuffer plus the queue of bytes still owed on the output
class raster_scoreboard #(int SCREEN_W = 128, int SCREEN_H = 64, int STORE_BYTES = 1024);
    logic [7:0]  frame_bytes [STORE_BYTES];
    logic [7:0]  owed_bytes [$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
        wipe();
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function void wipe();
        foreach (frame_bytes[i])
            frame_bytes[i] = '0;
    endfunction

    // off-screen pixels and bytes past the store are dropped
    function void plot(pfre_pkg::coord_t col, pfre_pkg::coord_t row, logic lit);
        int unsigned idx;
        if (col >= SCREEN_W || row >= SCREEN_H)
            return;
        idx = (int'(row) / 8) * SCREEN_W + int'(col);
        if (idx >= STORE_BYTES)
            return;
        frame_bytes[idx][row % 8] = lit;
    endfunction

    // membership in the span start .. start+len-1, taken modulo 2^16
    function bit in_span(pfre_pkg::coord_t c, pfre_pkg::coord_t start, pfre_pkg::coord_t len);
        pfre_pkg::coord_t offs;
        offs = c - start;
        return offs < len;
    endfunction

    function void paint_box(raster_cmd_t cmd, bit filled);
        pfre_pkg::coord_t right;
        pfre_pkg::coord_t bottom;
        bit row_in;
        bit col_in;
        bit hit;
        if (cmd.w == 0 || cmd.h == 0)
            return;
        right  = cmd.x + cmd.w - 16'd1;
        bottom = cmd.y + cmd.h - 16'd1;
        for (int r = 0; r < SCREEN_H; r++)
        begin
            row_in = in_span(16'(r), cmd.y, cmd.h);
            for (int c = 0; c < SCREEN_W; c++)
            begin
                col_in = in_span(16'(c), cmd.x, cmd.w);
                if (filled)
                    hit = col_in && row_in;
                else
                    hit = (col_in && (16'(r) == cmd.y || 16'(r) == bottom)) ||
                          (row_in && (16'(c) == cmd.x || 16'(c) == right));
                if (hit)
                    plot(16'(c), 16'(r), cmd.on);
            end
        end
    endfunction

    // apply one accepted command and queue the byte it must return
    function void note_cmd(raster_cmd_t cmd);
        logic [7:0] byte_out;
        int         rows;
        byte_out = '0;
        case (cmd.kind)
            pfre_pkg::KIND_CLEAR:   wipe();
            pfre_pkg::KIND_PIXEL:   plot(cmd.x, cmd.y, cmd.on);
            pfre_pkg::KIND_OUTLINE: paint_box(cmd, 1'b0);
            pfre_pkg::KIND_FILL:    paint_box(cmd, 1'b1);
            pfre_pkg::KIND_BLIT:
            begin
                rows = (cmd.h < 16'd8) ? int'(cmd.h) : 8;
                for (int k = 0; k < rows; k++)
                    if (cmd.data[k])
                        plot(cmd.x, cmd.y + 16'(k), 1'b1);
            end
            pfre_pkg::KIND_READ:
            begin
                if (cmd.read_address < STORE_BYTES)
                    byte_out = frame_bytes[cmd.read_address];
            end
            default: ;
        endcase
        owed_bytes.push_back(byte_out);
    endfunction

    function int pending();
        return owed_bytes.size();
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        mismatches++;
    endtask

    task check_result(logic [7:0] got);
        logic [7:0] want;
        results_seen++;
        if (owed_bytes.size() == 0)
            report($sformatf("read_data %02h arrived with nothing owed", got));
        else
        begin
            want = owed_bytes.pop_front();
            if (got !== want)
                report($sformatf("result %0d: read_data %02h, expected %02h",
                                 results_seen, got, want));
        end
    endtask
endclass

module tb_page_framebuffer_raster_engine;
    import pfre_pkg::*;

    localparam int SCREEN_W    = 128;
    localparam int SCREEN_H    = 64;
    localparam int STORE_BYTES = 1024;

    // kinds the block must treat as no-ops
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    localparam int RANDOM_PER_PHASE = 360;
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 64;
    // worst case is ~1100 items at a full-screen rectangle or clear each
    // plus stalls, taken several times over
    localparam int CYCLE_LIMIT      = 6_000_000;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic [2:0]       kind         = '0;
    coord_t           x            = '0;
    coord_t           y            = '0;
    coord_t           w            = '0;
    coord_t           h            = '0;
    logic             on           = 1'b0;
    logic [7:0]       data         = '0;
    logic [9:0]       read_address = '0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic [7:0]       read_data;

    // idle rates in percent per cycle
    int               tx_idle_pct  = 0;
    int               rx_idle_pct  = 0;

    // long receiver hold-off: a request bump starts a counted stretch
    int               hold_seq     = 0;
    int               hold_seen    = 0;
    int               hold_left    = 0;

    int unsigned      cycle_count  = 0;

    // last drawn spot, so reads often land on bytes that were just touched
    coord_t           last_x       = '0;
    coord_t           last_y       = '0;

    raster_scoreboard #(SCREEN_W, SCREEN_H, STORE_BYTES) sb;

    page_framebuffer_raster_engine #(
        .WIDTH       (SCREEN_W),
        .HEIGHT      (SCREEN_H),
        .STORE_BYTES (STORE_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .x            (x),
        .y            (y),
        .w            (w),
        .h            (h),
        .on           (on),
        .data         (data),
        .read_address (read_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // watchdog
    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // both channels sampled at the edge, before any driver update lands
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_cmd('{kind: kind, x: x, y: y, w: w, h: h, on: on,
                          data: data, read_address: read_address});
        if (rst_n && out_valid && !out_stall)
            sb.check_result(read_data);
    end

    // result side: random stalls, or a long counted hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    function automatic raster_cmd_t mk(logic [2:0] k, coord_t cx, coord_t cy, coord_t cw,
                                       coord_t ch, logic lit, logic [7:0] bits,
                                       logic [9:0] addr);
        raster_cmd_t cmd;
        cmd = '{kind: k, x: cx, y: cy, w: cw, h: ch, on: lit, data: bits, read_address: addr};
        return cmd;
    endfunction

    // mostly on or near the screen, some near the wrap point, some anywhere
    function automatic coord_t pick_coord(int screen_max);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75)
            return 16'($urandom_range(0, screen_max + 6));
        if (r < 90)
            return 16'hFFFF - 16'($urandom_range(0, 24));
        return 16'($urandom);
    endfunction

    // rectangle extents: mostly small to keep the page walk short
    function automatic coord_t pick_span(int typical_max, int full_max);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return '0;
        if (r < 78)
            return 16'($urandom_range(1, typical_max));
        if (r < 94)
            return 16'($urandom_range(typical_max + 1, full_max));
        return 16'($urandom);
    endfunction

    // light picks only pixel, blit and read commands
    function automatic raster_cmd_t random_cmd(bit light);
        raster_cmd_t cmd;
        int unsigned r;
        // don't-care fields stay random so every bit toggles
        cmd.x            = 16'($urandom);
        cmd.y            = 16'($urandom);
        cmd.w            = 16'($urandom);
        cmd.h            = 16'($urandom);
        cmd.on           = 1'($urandom);
        cmd.data         = 8'($urandom);
        cmd.read_address = 10'($urandom);
        r = light ? $urandom_range(22, 93) : $urandom_range(99);
        if (r < 2)
            cmd.kind = KIND_CLEAR;
        else if (r < 22)
        begin
            cmd.kind = (r < 12) ? KIND_OUTLINE : KIND_FILL;
            cmd.x    = pick_coord(SCREEN_W);
            cmd.y    = pick_coord(SCREEN_H);
            cmd.w    = pick_span(24, SCREEN_W + 8);
            cmd.h    = pick_span(10, SCREEN_H + 8);
            last_x   = cmd.x;
            last_y   = cmd.y;
        end
        else if (r < 58)
        begin
            cmd.kind = (r < 42) ? KIND_PIXEL : KIND_BLIT;
            cmd.x    = pick_coord(SCREEN_W);
            cmd.y    = pick_coord(SCREEN_H);
            if (cmd.kind == KIND_BLIT && $urandom_range(99) < 85)
                cmd.h = 16'($urandom_range(0, 9));
            last_x   = cmd.x;
            last_y   = cmd.y;
        end
        else if (r < 94)
        begin
            cmd.kind = KIND_READ;
            if ($urandom_range(1) == 1 && last_x < SCREEN_W && last_y < SCREEN_H)
                cmd.read_address = 10'((int'(last_y) / 8) * SCREEN_W + int'(last_x));
        end
        else
            cmd.kind = $urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7;
        return cmd;
    endfunction

    // offer one word, after a random idle gap, and hold it until taken;
    // valid is only lowered when a gap really follows
    task automatic send_cmd(input raster_cmd_t cmd);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind         <= cmd.kind;
        x            <= cmd.x;
        y            <= cmd.y;
        w            <= cmd.w;
        h            <= cmd.h;
        on           <= cmd.on;
        data         <= cmd.data;
        read_address <= cmd.read_address;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop offering and wait for every owed byte to come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        raster_cmd_t plan [$];
        sb = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 35;
        rx_idle_pct <= 46;

        // directed: corners, off-screen clipping, wrap-around, zero sizes,
        // whole-screen fill, blit row limits and the no-op kinds
        plan.push_back(mk(KIND_READ,    16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 8'h00, 10'd0));
        plan.push_back(mk(KIND_PIXEL,   16'd0,     16'd0,     16'd0,     16'd0,     1'b1, 8'h00, 10'd0));
        plan.push_back(mk(KIND_PIXEL,   16'd127,   16'd63,    16'hFFFF,  16'hFFFF,  1'b1, 8'hFF, 10'h3FF));
        plan.push_back(mk(KIND_PIXEL,   16'd128,   16'd5,     16'd0,     16'd0,     1'b1, 8'h00, 10'd0));
        plan.push_back(mk(KIND_PIXEL,   16'd3,     16'd64,    16'd0,     16'd0,     1'b1, 8'h00, 10'd0));
        plan.push_back(mk(KIND_PIXEL,   16'hFFFF,  16'hFFFF,  16'd0,     16'd0,     1'b1, 8'h00, 10'd0));
        plan.push_back(mk(KIND_READ,    16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 8'h00, 10'd0));
        plan.push_back(mk(KIND_READ,    16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 8'h00, 10'h3FF));
        plan.push_back(mk(KIND_PIXEL,   16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 8'h00, 10'd0));
        // outline wrapping past 65535 on both axes back onto the screen
        plan.push_back(mk(KIND_OUTLINE, 16'd65530, 16'd65534, 16'd20,    16'd12,    1'b1, 8'h00, 10'd0));
        plan.push_back(mk(KIND_READ,    16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 8'h00, 10'd13));
        plan.push_back(mk(KIND_FILL,    16'd10,    16'd10,    16'd0,     16'd5,     1'b1, 8'h00, 10'd0));
        plan.push_back(mk(KIND_FILL,    16'd10,    16'd10,    16'd5,     16'd0,     1'b1, 8'h00, 10'd0));
        plan.push_back(mk(KIND_FILL,    16'd0,     16'd0,     16'd128,   16'd64,    1'b1, 8'h00, 10'd0));
        plan.push_back(mk(KIND_READ,    16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 8'h00, 10'd517));
        // near-full-range outline clearing pixels
        plan.push_back(mk(KIND_OUTLINE, 16'd2,     16'd3,     16'hFFFF,  16'hFFFF,  1'b0, 8'h00, 10'd0));
        plan.push_back(mk(KIND_READ,    16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 8'h00, 10'd130));
        plan.push_back(mk(KIND_CLEAR,   16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 8'h00, 10'd0));
        // blit across a page boundary, past the bottom, zero rows, wrapped rows
        plan.push_back(mk(KIND_BLIT,    16'd5,     16'd3,     16'd0,     16'd8,     1'b0, 8'hA5, 10'd0));
        plan.push_back(mk(KIND_BLIT,    16'd6,     16'd60,    16'hFFFF,  16'hFFFF,  1'b0, 8'hFF, 10'd0));
        plan.push_back(mk(KIND_BLIT,    16'd7,     16'd0,     16'd0,     16'd0,     1'b1, 8'hFF, 10'd0));
        plan.push_back(mk(KIND_BLIT,    16'd8,     16'd65534, 16'd0,     16'd3,     1'b1, 8'h07, 10'd0));
        plan.push_back(mk(KIND_READ,    16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 8'h00, 10'd5));
        plan.push_back(mk(KIND_READ,    16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 8'h00, 10'd133));
        plan.push_back(mk(KIND_SPARE_6, 16'd1,     16'd1,     16'd4,     16'd4,     1'b1, 8'hFF, 10'd8));
        plan.push_back(mk(KIND_SPARE_7, 16'd1,     16'd1,     16'd4,     16'd4,     1'b1, 8'hFF, 10'd8));
        plan.push_back(mk(KIND_READ,    16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 8'h00, 10'd8));
        foreach (plan[i])
            send_cmd(plan[i]);
        drain();

        // random phases: receiver idles more, then sender, then neither;
        // each phase starts a long receiver hold-off while light commands
        // keep coming, then drains fully before the next phase
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 46 : 0;
            rx_idle_pct <= (phase == 0) ? 46 : (phase == 1) ? 35 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n == 40)
                    hold_seq <= hold_seq + 1;
                send_cmd(random_cmd(n >= 40 && n < 80));
            end
            drain();
        end

        // catch any stray word after the last owed byte
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
